[rtl/core/oid_content_decoder_defines.svh]
// Assertion macros for the object identifier content decoder.
`ifndef OID_CONTENT_DECODER_DEFINES_SVH
`define OID_CONTENT_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define OIDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define OIDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/oidc_pkg.sv]
// Shared types and constants of the object identifier content decoder.
package oidc_pkg;

	localparam int MAX_ARCS  = 64;
	localparam int MIN_ARCS  = 2;
	localparam int MAX_BYTES = 5;
	localparam int QDEPTH    = 4;
	localparam int QAW       = $clog2(QDEPTH);

	localparam logic [6:0]  CFG_RESET = 7'd64;
	localparam logic [31:0] ARC1_BASE = 32'd40;
	localparam logic [31:0] ARC2_BASE = 32'd80;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_INVALID   = 2'd2,
		ST_TOO_SMALL = 2'd3
	} status_t;

	typedef struct packed {
		logic        split;
		logic [31:0] value;
		logic [5:0]  index;
		status_t     status;
		logic        done;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_beat_t;

endpackage

[rtl/core/oidc_front.sv]
// Front end: accepts content bytes, tracks subidentifier state, issues commands.
module oidc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [6:0]          cfg_wr_data,
	input  logic                in_valid,
	input  logic [7:0]          content_byte,
	input  logic                final_byte,
	input  logic                q_full,
	output logic                in_stall,
	output oidc_pkg::cmd_beat_t push
);
	import oidc_pkg::*;

	logic [6:0]  max_q;
	logic [31:0] acc_q;
	logic [2:0]  bytes_q;
	logic        first_q;
	logic [6:0]  count_q;
	logic        disc_q;

	logic [31:0] acc_n;
	logic [2:0]  bytes_n;
	logic        first_n;
	logic [6:0]  count_n;
	logic        disc_n;
	logic [6:0]  limit;
	logic        accept;
	logic [31:0] acc_shift;

	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign acc_shift = {acc_q[24:0], content_byte[6:0]};

	always_comb begin
		if (max_q > 7'(MAX_ARCS)) begin
			limit = 7'(MAX_ARCS);
		end else if (max_q < 7'(MIN_ARCS)) begin
			limit = 7'(MIN_ARCS);
		end else begin
			limit = max_q;
		end
	end

	always_comb begin
		acc_n            = acc_q;
		bytes_n          = bytes_q;
		first_n          = first_q;
		count_n          = count_q;
		disc_n           = disc_q;
		push.valid       = 1'b0;
		push.cmd.split   = 1'b0;
		push.cmd.value   = '0;
		push.cmd.index   = count_q[5:0];
		push.cmd.status  = ST_OK;
		push.cmd.done    = 1'b1;
		if (accept) begin
			if (disc_q) begin
				// drop until the final byte
			end else if (bytes_q == '0 && !first_q && count_q >= limit) begin
				push.valid      = 1'b1;
				push.cmd.status = ST_TOO_SMALL;
				disc_n          = 1'b1;
			end else if (bytes_q == 3'(MAX_BYTES)) begin
				push.valid      = 1'b1;
				push.cmd.status = ST_OVERFLOW;
				disc_n          = 1'b1;
			end else if (content_byte[7]) begin
				acc_n   = acc_shift;
				bytes_n = bytes_q + 3'd1;
				if (final_byte) begin
					push.valid      = 1'b1;
					push.cmd.status = ST_INVALID;
				end
			end else begin
				push.valid     = 1'b1;
				push.cmd.value = acc_shift;
				push.cmd.done  = final_byte;
				acc_n          = '0;
				bytes_n        = '0;
				if (first_q) begin
					push.cmd.split = 1'b1;
					push.cmd.index = '0;
					first_n        = 1'b0;
					count_n        = 7'd2;
				end else begin
					count_n = count_q + 7'd1;
				end
			end
			if (final_byte) begin
				acc_n   = '0;
				bytes_n = '0;
				first_n = 1'b1;
				count_n = '0;
				disc_n  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= CFG_RESET;
			acc_q   <= '0;
			bytes_q <= '0;
			first_q <= 1'b1;
			count_q <= '0;
			disc_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end
			acc_q   <= acc_n;
			bytes_q <= bytes_n;
			first_q <= first_n;
			count_q <= count_n;
			disc_q  <= disc_n;
		end
	end

endmodule

[rtl/core/oidc_queue.sv]
// Command queue between the front end and the output stage.
module oidc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  oidc_pkg::cmd_beat_t push,
	input  logic                pop,
	output logic                full,
	output oidc_pkg::cmd_beat_t head
);
	import oidc_pkg::*;

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_push;
	logic           do_pop;

	assign full       = (count_q == (QAW+1)'(QDEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd   = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QAW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QAW+1)'(1);
			end
		end
	end

endmodule

[rtl/core/oidc_back.sv]
// Output stage: splits the first subidentifier and drives result beats.
module oidc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  oidc_pkg::cmd_beat_t head,
	output logic                pop,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [31:0]         arc_value,
	output logic [5:0]          arc_index,
	output logic [1:0]          status,
	output logic                done_res
);
	import oidc_pkg::*;

	logic        valid_q;
	logic [31:0] value_q;
	logic [5:0]  index_q;
	status_t     status_q;
	logic        done_q;
	logic        rest_pend_q;
	logic [31:0] rest_val_q;
	logic        rest_done_q;

	logic        load;
	logic [31:0] top;
	logic [31:0] rest;

	assign load = !valid_q || !out_stall;
	assign pop  = load && !rest_pend_q && head.valid;

	always_comb begin
		if (head.cmd.value < ARC1_BASE) begin
			top  = 32'd0;
			rest = head.cmd.value;
		end else if (head.cmd.value < ARC2_BASE) begin
			top  = 32'd1;
			rest = head.cmd.value - ARC1_BASE;
		end else begin
			top  = 32'd2;
			rest = head.cmd.value - ARC2_BASE;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (rest_pend_q) begin
				value_q  <= rest_val_q;
				index_q  <= 6'd1;
				status_q <= ST_OK;
				done_q   <= rest_done_q;
			end else if (head.cmd.split) begin
				value_q  <= top;
				index_q  <= 6'd0;
				status_q <= ST_OK;
				done_q   <= 1'b0;
			end else begin
				value_q  <= head.cmd.value;
				index_q  <= head.cmd.index;
				status_q <= head.cmd.status;
				done_q   <= head.cmd.done;
			end
		end
		if (pop) begin
			rest_val_q  <= rest;
			rest_done_q <= head.cmd.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			rest_pend_q <= 1'b0;
		end else if (load) begin
			valid_q     <= rest_pend_q || head.valid;
			rest_pend_q <= pop && head.cmd.split;
		end
	end

	assign out_valid = valid_q;
	assign arc_value = value_q;
	assign arc_index = index_q;
	assign status    = status_q;
	assign done_res  = done_q;

endmodule

[rtl/core/oid_content_decoder.sv]
// Top level of the object identifier content decoder.
// Takes one content byte per cycle and returns arcs, one beat per cycle, while
// not stalled. A byte is accepted while the four-entry command queue has room;
// a completed arc's command is written into the queue and then registered in
// the output stage. The first subidentifier yields two beats from one queue
// entry, and no new entry is popped until the second is loaded; every other
// arc or error gives one. An error beat ends the identifier and later bytes
// up to the final one give no beat. The user must write max_components via
// cfg_wr_en/cfg_wr_data only while idle (unenforced); values clamp to 2..64.
module oid_content_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  content_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] arc_value,
	output logic [5:0]  arc_index,
	output logic [1:0]  status,
	output logic        done_res
);
	import oidc_pkg::*;

	cmd_beat_t push;
	cmd_beat_t head;
	logic      q_full;
	logic      pop;

	oidc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.content_byte (content_byte),
		.final_byte   (final_byte),
		.q_full       (q_full),
		.in_stall     (in_stall),
		.push         (push)
	);

	oidc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	oidc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.arc_value (arc_value),
		.arc_index (arc_index),
		.status    (status),
		.done_res  (done_res)
	);

endmodule

[rtl/core/oidc_checker.sv]
// Port-level checks on the decoder's result channel, bound to the top level.
`include "oid_content_decoder_defines.svh"

module oidc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] arc_value,
	input logic [5:0]  arc_index,
	input logic [1:0]  status,
	input logic        done_res
);
	import oidc_pkg::*;

	`OIDC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(arc_value) && $stable(arc_index) && $stable(status) && $stable(done_res), "stalled result beat changed")
	`OIDC_ASSERT_NOW(a_err_done, clk, arst_n, out_valid && status != ST_OK, done_res && arc_value == 32'd0, "error beat not final or carries a value")
	`OIDC_ASSERT_NOW(a_first_not_last, clk, arst_n, out_valid && status == ST_OK && arc_index == 6'd0, !done_res && arc_value <= 32'd2, "first arc malformed")
	`OIDC_ASSERT_NEXT(a_second_follows, clk, arst_n, out_valid && !out_stall && status == ST_OK && arc_index == 6'd0, out_valid && status == ST_OK && arc_index == 6'd1, "second arc does not follow first")

endmodule

bind oid_content_decoder oidc_checker u_oidc_checker (.*);

[tb/oid_arc_checker_pkg.sv]
// Arc predictor and result checker for the object identifier content decoder testbench.
package oid_arc_checker_pkg;
	import oidc_pkg::*;

	typedef struct {
		logic [31:0] value;
		logic [5:0]  index;
		status_t     st;
		logic        done;
	} arc_beat_t;

	class oid_arc_checker;
		arc_beat_t   expected_arcs[$];
		int          mismatches;
		logic [6:0]  max_components;
		logic [31:0] acc;
		int          nbytes;
		bit          first_pending;
		logic [6:0]  arc_count;
		bit          discarding;

		function new();
			mismatches = 0;
			max_components = CFG_RESET;
			restart();
		endfunction

		function void restart();
			acc = '0;
			nbytes = 0;
			first_pending = 1'b1;
			arc_count = '0;
			discarding = 1'b0;
		endfunction

		function void set_limit(logic [6:0] v);
			max_components = v;
		endfunction

		function int active_limit();
			int lim;
			lim = max_components;
			if (lim > MAX_ARCS)
				lim = MAX_ARCS;
			if (lim < MIN_ARCS)
				lim = MIN_ARCS;
			return lim;
		endfunction

		function int waiting();
			return expected_arcs.size();
		endfunction

		function void push(logic [31:0] value, logic [5:0] index, status_t st, logic done);
			arc_beat_t e;
			e.value = value;
			e.index = index;
			e.st = st;
			e.done = done;
			expected_arcs.push_back(e);
		endfunction

		function void raise(status_t st, logic fin);
			push('0, arc_count[5:0], st, 1'b1);
			if (fin)
				restart();
			else
				discarding = 1'b1;
		endfunction

		function void take_byte(logic [7:0] b, logic fin);
			logic [31:0] v;
			if (discarding) begin
				if (fin)
					restart();
				return;
			end
			if (nbytes == 0 && !first_pending && arc_count >= active_limit()) begin
				raise(ST_TOO_SMALL, fin);
				return;
			end
			nbytes++;
			if (nbytes > MAX_BYTES) begin
				raise(ST_OVERFLOW, fin);
				return;
			end
			acc = {acc[24:0], b[6:0]};
			if (b[7]) begin
				if (fin)
					raise(ST_INVALID, 1'b1);
				return;
			end
			if (first_pending) begin
				v = acc;
				if (v < ARC1_BASE) begin
					push(32'd0, 6'd0, ST_OK, 1'b0);
					push(v, 6'd1, ST_OK, fin);
				end else if (v < ARC2_BASE) begin
					push(32'd1, 6'd0, ST_OK, 1'b0);
					push(v - ARC1_BASE, 6'd1, ST_OK, fin);
				end else begin
					push(32'd2, 6'd0, ST_OK, 1'b0);
					push(v - ARC2_BASE, 6'd1, ST_OK, fin);
				end
				first_pending = 1'b0;
				arc_count = 7'd2;
			end else begin
				push(acc, arc_count[5:0], ST_OK, fin);
				arc_count = arc_count + 7'd1;
			end
			acc = '0;
			nbytes = 0;
			if (fin)
				restart();
		endfunction

		function void match_arc(logic [31:0] value, logic [5:0] index, logic [1:0] st,
				logic done);
			arc_beat_t e;
			if (expected_arcs.size() == 0) begin
				$error("unexpected arc beat: arc_value %0d arc_index %0d status %0d done_res %0d",
					value, index, st, done);
				mismatches++;
				return;
			end
			e = expected_arcs.pop_front();
			if (value !== e.value) begin
				$error("arc_value: expected %0d, got %0d", e.value, value);
				mismatches++;
			end
			if (index !== e.index) begin
				$error("arc_index: expected %0d, got %0d", e.index, index);
				mismatches++;
			end
			if (st !== e.st) begin
				$error("status: expected %0d, got %0d", e.st, st);
				mismatches++;
			end
			if (done !== e.done) begin
				$error("done_res: expected %0d, got %0d", e.done, done);
				mismatches++;
			end
		endfunction
	endclass

endpackage

[tb/oid_content_decoder_tb.sv]
// Top-level testbench of the object identifier content decoder.
module oid_content_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import oidc_pkg::*;
	import oid_arc_checker_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int SEG_BYTES   = 150;
	localparam logic [8:0] DIRECTED [22] = '{
		9'h02A, 9'h086, 9'h148,
		9'h100,
		9'h17F,
		9'h001, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h17F,
		9'h000, 9'h081, 9'h081, 9'h081, 9'h081, 9'h081, 9'h001, 9'h105,
		9'h02A, 9'h181,
		9'h180
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [6:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  content_byte;
	logic        final_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] arc_value;
	logic [5:0]  arc_index;
	logic [1:0]  status;
	logic        done_res;

	oid_arc_checker sb;
	int             send_idle = 0;
	int             recv_idle = 0;
	int             stuck_cycles = 0;
	int             sent_bytes;
	int             cur_limit;
	logic [7:0]     oid_bytes[$];
	logic [6:0]     limit_plan[9];

	oid_content_decoder u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.content_byte(content_byte),
		.final_byte  (final_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.arc_value   (arc_value),
		.arc_index   (arc_index),
		.status      (status),
		.done_res    (done_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.take_byte(content_byte, final_byte);
		if (arst_n && out_valid && !out_stall)
			sb.match_arc(arc_value, arc_index, status, done_res);
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		while (stuck_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		content_byte <= b;
		final_byte <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_limit(input logic [6:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.waiting() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_limit(v);
		cur_limit = sb.active_limit();
	endtask

	function automatic void add_subid();
		int r;
		int len;
		logic [7:0] b;
		r = $urandom_range(99);
		if (r < 80)
			len = $urandom_range(1, 3);
		else if (r < 96)
			len = $urandom_range(4, 5);
		else
			len = $urandom_range(6, 7);
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(127));
			if (i < len - 1)
				b[7] = 1'b1;
			oid_bytes.push_back(b);
		end
	endfunction

	task automatic send_oid();
		int kind;
		int narcs;
		bit noise;
		kind = $urandom_range(99);
		noise = (kind < 6);
		oid_bytes.delete();
		if (noise) begin
			repeat ($urandom_range(1, 8))
				oid_bytes.push_back(8'($urandom));
		end else begin
			if ($urandom_range(9) == 0)
				narcs = $urandom_range(0, cur_limit + 1);
			else
				narcs = $urandom_range(0, 3);
			for (int a = 0; a <= narcs; a++)
				add_subid();
			if (kind < 14)
				oid_bytes.push_back(8'h80 | 8'($urandom_range(127)));
		end
		foreach (oid_bytes[i])
			send_byte(oid_bytes[i], (i == oid_bytes.size() - 1) ||
				(noise && $urandom_range(7) == 0));
		sent_bytes += oid_bytes.size();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		content_byte = '0;
		final_byte = 1'b0;
		sb = new();
		cur_limit = sb.active_limit();
		limit_plan = '{7'd2, 7'd127, 7'd0, 7'd64, 7'd1, 7'd3, 7'($urandom_range(127)),
			7'd65, 7'd5};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
		write_limit(7'd0);
		send_byte(8'h2A, 1'b0);
		send_byte(8'h01, 1'b1);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 33 : (phase == 1) ? 88 : 0;
			recv_idle = (phase == 0) ? 88 : (phase == 1) ? 33 : 0;
			for (int seg = 0; seg < 3; seg++) begin
				write_limit(limit_plan[phase * 3 + seg]);
				sent_bytes = 0;
				while (sent_bytes < SEG_BYTES)
					send_oid();
			end
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (sb.waiting() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/oidc_pkg.sv
rtl/core/oidc_front.sv
rtl/core/oidc_queue.sv
rtl/core/oidc_back.sv
rtl/core/oid_content_decoder.sv
rtl/core/oidc_checker.sv
tb/oid_arc_checker_pkg.sv
tb/oid_content_decoder_tb.sv
